// ===== rtl/tcbm_pkg.sv =====
// shared types and constants for the transmit chunk buffer manager
// no dependencies; used by tcbm_front, tcbm_back and tx_chunk_buffer_manager
package tcbm_pkg;

   localparam int BUFFER_DEPTH_DEF = 1024;
   localparam int CHUNK_SLOTS_DEF  = 16;

   typedef enum logic [1:0] {
      FN_WRITE    = 2'd0,
      FN_COMPLETE = 2'd1,
      FN_CONNECT  = 2'd2,
      FN_READ     = 2'd3
   } func_type;

   typedef struct packed {
      func_type    op;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        engine_idle;
      logic [9:0]  read_index;
   } item_type;

   typedef struct packed {
      logic        byte_accepted;
      logic        tx_start_valid;
      logic [9:0]  tx_start_pos;
      logic [10:0] tx_length;
      logic [7:0]  read_data;
   } result_type;

endpackage

// ===== rtl/tcbm_front.sv =====
// input side: accepts stream items, decodes the function code and queues them
// depends on tcbm_pkg
module tcbm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [23:0]        req_tdata,
   input  logic               req_tlast,
   input  logic [1:0]         req_tuser,
   output logic               item_valid,
   output tcbm_pkg::item_type item,
   input  logic               item_pop
);
   import tcbm_pkg::*;

   item_type   queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   decoded;

   always_comb begin
      decoded.op          = func_type'(req_tuser);
      decoded.data_byte   = req_tdata[7:0];
      decoded.last_byte   = req_tlast;
      decoded.engine_idle = req_tdata[8];
      decoded.read_index  = req_tdata[18:9];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== rtl/tcbm_back.sv =====
// execution side: byte ring, chunk end marks, pointer update and descriptor issue
// depends on tcbm_pkg; fed by tcbm_front
module tcbm_back #(
   parameter int BUFFER_DEPTH = tcbm_pkg::BUFFER_DEPTH_DEF,
   parameter int CHUNK_SLOTS  = tcbm_pkg::CHUNK_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  tcbm_pkg::item_type   item,
   output logic                 item_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_taken,
   output tcbm_pkg::result_type rsp
);
   import tcbm_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = AW + 1;
   localparam int SW = $clog2(CHUNK_SLOTS);
   localparam logic [LW-1:0] DEPTH_L = LW'(BUFFER_DEPTH);
   localparam logic [SW-1:0] LAST_SLOT = SW'(CHUNK_SLOTS - 1);

   typedef enum logic {ST_FETCH, ST_EXEC} state_type;

   function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] i);
      return (i == LAST_SLOT) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] i);
      return (i == '0) ? LAST_SLOT : i - 1'b1;
   endfunction

   logic [7:0]    byte_mem [BUFFER_DEPTH];
   logic [AW-1:0] mark_mem [CHUNK_SLOTS];

   state_type     state_ff, state_in;
   item_type      cur_ff, cur_in;
   logic [AW-1:0] committed_head_ff, committed_head_in;
   logic [AW-1:0] send_tail_ff, send_tail_in;
   logic [SW-1:0] cq_head_ff, cq_head_in;
   logic [SW-1:0] cq_tail_ff, cq_tail_in;
   logic [LW-1:0] working_head_ff, working_head_in;
   logic [LW-1:0] segment_limit_ff, segment_limit_in;
   logic          segment_open_ff, segment_open_in;
   logic          discarding_ff, discarding_in;
   logic          transmitting_ff, transmitting_in;
   logic          connected_ff, connected_in;
   logic          out_valid_ff, out_valid_in;
   result_type    out_ff, out_in;

   logic [AW-1:0] mark_a_ff, mark_b_ff;
   logic [7:0]    byte_rd_ff;
   logic [SW-1:0] mark_addr_b;
   logic          fetch, exec_go;

   logic          byte_we;
   logic [AW-1:0] byte_waddr;
   logic          mark_we;
   logic [SW-1:0] mark_waddr;
   logic [AW-1:0] mark_wdata;

   assign fetch    = (state_ff == ST_FETCH) && item_valid;
   assign exec_go  = (state_ff == ST_EXEC) && (!out_valid_ff || rsp_taken);
   assign item_pop = fetch;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // second mark port: next slot for completion, newest chunk otherwise
   assign mark_addr_b = (item.op == FN_COMPLETE) ? slot_next(cq_tail_ff)
                                                 : slot_prev(cq_head_ff);

   always_ff @(posedge clock) begin
      if (fetch) begin
         byte_rd_ff <= byte_mem[AW'(item.read_index)];
      end
      if (byte_we) begin
         byte_mem[byte_waddr] <= cur_ff.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch) begin
         mark_a_ff <= mark_mem[cq_tail_ff];
         mark_b_ff <= mark_mem[mark_addr_b];
      end
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
   end

   always_comb begin
      logic [AW-1:0] ch, st, newest, pos, end_t;
      logic [SW-1:0] qh, qt, nh, p;
      logic [LW-1:0] wh, lim, end_l, start_l;
      logic [LW:0]   len;
      logic          drop, issue, merge;

      state_in          = state_ff;
      cur_in            = cur_ff;
      committed_head_in = committed_head_ff;
      send_tail_in      = send_tail_ff;
      cq_head_in        = cq_head_ff;
      cq_tail_in        = cq_tail_ff;
      working_head_in   = working_head_ff;
      segment_limit_in  = segment_limit_ff;
      segment_open_in   = segment_open_ff;
      discarding_in     = discarding_ff;
      transmitting_in   = transmitting_ff;
      connected_in      = connected_ff;
      out_valid_in      = out_valid_ff && !rsp_taken;
      out_in            = out_ff;
      byte_we    = 1'b0;
      byte_waddr = '0;
      mark_we    = 1'b0;
      mark_waddr = '0;
      mark_wdata = '0;

      ch = committed_head_ff;  st = send_tail_ff;
      qh = cq_head_ff;         qt = cq_tail_ff;
      wh = working_head_ff;    lim = segment_limit_ff;
      newest = mark_b_ff;      pos = '0;
      end_t = mark_a_ff;       nh = '0;  p = '0;
      drop = 1'b0;  issue = 1'b0;  merge = 1'b0;
      end_l = '0;  start_l = '0;  len = '0;

      if (fetch) begin
         cur_in   = item;
         state_in = ST_EXEC;
      end

      if (exec_go) begin
         state_in     = ST_FETCH;
         out_valid_in = 1'b1;
         out_in       = '0;
         case (cur_ff.op)
            FN_WRITE: begin
               if (discarding_ff) begin
                  if (cur_ff.last_byte) discarding_in = 1'b0;
               end else begin
                  if (!segment_open_ff) begin
                     if (ch == st && qh != qt) begin
                        if (transmitting_ff) begin
                           // ring full: keep only the chunk in flight
                           qh = slot_next(qt);
                           ch = mark_a_ff;
                           newest = mark_a_ff;
                           if (ch == st) begin
                              drop = 1'b1;
                              if (!cur_ff.last_byte) discarding_in = 1'b1;
                           end
                        end else begin
                           qh = '0;  qt = '0;  ch = '0;  st = '0;
                        end
                     end
                     if (!drop) begin
                        wh = LW'(ch);
                        lim = (ch < st) ? LW'(st) : DEPTH_L;
                        segment_open_in = 1'b1;
                     end
                  end
                  if (!drop) begin
                     byte_we    = 1'b1;
                     byte_waddr = wh[AW-1:0];
                     wh = wh + 1'b1;
                     out_in.byte_accepted = 1'b1;
                     if (cur_ff.last_byte || wh >= lim) begin
                        segment_open_in = 1'b0;
                        pos = (wh >= DEPTH_L) ? '0 : wh[AW-1:0];
                        merge = (qh != qt) && (slot_next(qt) != qh) && (newest != '0);
                        p = slot_prev(qh);
                        mark_we    = 1'b1;
                        mark_wdata = pos;
                        if (merge) begin
                           mark_waddr = p;
                           ch = pos;
                           end_t = (p == qt) ? pos : mark_a_ff;
                           issue = 1'b1;
                        end else begin
                           mark_waddr = qh;
                           nh = slot_next(qh);
                           if (nh == qt) begin
                              // chunk queue full
                              out_in.byte_accepted = 1'b0;
                              if (!cur_ff.last_byte) discarding_in = 1'b1;
                           end else begin
                              ch = pos;
                              end_t = (qh == qt) ? pos : mark_a_ff;
                              qh = nh;
                              issue = 1'b1;
                           end
                        end
                     end
                  end
                  committed_head_in = ch;
                  send_tail_in      = st;
                  cq_head_in        = qh;
                  cq_tail_in        = qt;
                  working_head_in   = wh;
                  segment_limit_in  = lim;
               end
            end
            FN_COMPLETE: begin
               if (qh != qt) begin
                  st = mark_a_ff;
                  qt = slot_next(qt);
                  end_t = mark_b_ff;
                  transmitting_in = 1'b0;
                  send_tail_in = st;
                  cq_tail_in   = qt;
                  issue = 1'b1;
               end
            end
            FN_CONNECT: begin
               if (!connected_ff) begin
                  connected_in = 1'b1;
                  issue = 1'b1;
               end
            end
            FN_READ: begin
               if ({22'd0, cur_ff.read_index} < 32'(BUFFER_DEPTH)) begin
                  out_in.read_data = byte_rd_ff;
               end
            end
            default: ;
         endcase

         if (issue && qh != qt && cur_ff.engine_idle &&
             (connected_ff || cur_ff.op == FN_CONNECT)) begin
            start_l = LW'(st);
            end_l   = (end_t == '0) ? DEPTH_L : LW'(end_t);
            len = (end_l >= start_l) ? (LW+1)'(end_l) - (LW+1)'(start_l)
                                     : (LW+1)'(end_l) + (LW+1)'(DEPTH_L)
                                       - (LW+1)'(start_l);
            out_in.tx_start_valid = 1'b1;
            out_in.tx_start_pos   = 10'(start_l);
            out_in.tx_length      = 11'(len);
            transmitting_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_FETCH;
         committed_head_ff <= '0;
         send_tail_ff      <= '0;
         cq_head_ff        <= '0;
         cq_tail_ff        <= '0;
         working_head_ff   <= '0;
         segment_limit_ff  <= '0;
         segment_open_ff   <= 1'b0;
         discarding_ff     <= 1'b0;
         transmitting_ff   <= 1'b0;
         connected_ff      <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         committed_head_ff <= committed_head_in;
         send_tail_ff      <= send_tail_in;
         cq_head_ff        <= cq_head_in;
         cq_tail_ff        <= cq_tail_in;
         working_head_ff   <= working_head_in;
         segment_limit_ff  <= segment_limit_in;
         segment_open_ff   <= segment_open_in;
         discarding_ff     <= discarding_in;
         transmitting_ff   <= transmitting_in;
         connected_ff      <= connected_in;
         out_valid_ff      <= out_valid_in;
      end
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

endmodule

// ===== rtl/tx_chunk_buffer_manager.sv =====
// channel  direction  tdata fields (low bit up)                             tlast      tuser
// req_     in         data_byte[7:0] engine_idle[8] read_index[18:9]      last_byte  func
// rsp_     out        byte_accepted tx_start_valid tx_start_pos tx_length  -          -
//                     read_data
// in the back end each item passes a fetch state, which reads the ring and the chunk
// mark table, and an execute state, which updates pointers, writes and registers the result.
// the front queue holds two items; with items back to back it fills and req_tready
// drops, as the back end takes no new item before it is through with the last one.
// a stalled result holds the back end; the front keeps filling until it is full.
// reset is synchronous and clears all pointers at once; the ring needs no clearing.
module tx_chunk_buffer_manager #(
   parameter int BUFFER_DEPTH = tcbm_pkg::BUFFER_DEPTH_DEF,
   parameter int CHUNK_SLOTS  = tcbm_pkg::CHUNK_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_byte, engine_idle, read_index
   input  logic        req_tlast,
   input  logic [1:0]  req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // byte_accepted, tx_start_valid, tx_start_pos,
                                   // tx_length, read_data
);
   import tcbm_pkg::*;

   logic       item_valid, item_pop;
   item_type   item;
   result_type rsp;

   tcbm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   tcbm_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .CHUNK_SLOTS  (CHUNK_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_taken  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.read_data, rsp.tx_length, rsp.tx_start_pos,
                       rsp.tx_start_valid, rsp.byte_accepted};

endmodule

// ===== rtl/tcbm_checker.sv =====
// port-level checks for tx_chunk_buffer_manager, bound to the top level
// depends only on the top-level ports
module tcbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_no_desc_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[22:2] == 21'd0)
      else $error("descriptor fields without descriptor");

   a_write_or_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[30:23] == 8'd0)
      else $error("read data on a write result");

endmodule

bind tx_chunk_buffer_manager tcbm_checker u_tcbm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/tx_chunk_buffer_manager_tb.sv =====
// testbench for tx_chunk_buffer_manager: drives byte writes, completions, connects and reads
// depends on tcbm_pkg; a scoreboard class predicts each result item and checks it in order
module tx_chunk_buffer_manager_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcbm_pkg::*;

   localparam int DEPTH = 1024;
   localparam int SLOTS = 16;
   localparam int MAX_CYCLES = 400000;

   // packed from the top bit down, so byte_accepted lands in bit 0
   typedef struct packed {
      logic [7:0]  rdata;
      logic [10:0] length;
      logic [9:0]  start_pos;
      logic        start_valid;
      logic        accepted;
   } tx_result;

   class chunk_ring_scoreboard;
      logic [7:0] ring [DEPTH];
      logic [9:0] marks [SLOTS];
      logic       ring_written [DEPTH];
      int unsigned commit_head, tail_pos, q_head, q_tail, wr_head, limit;
      bit seg_open, dropping, sending, connected;
      tx_result pending [$];
      int errors;

      function new();
         foreach (ring_written[i]) ring_written[i] = 0;
         foreach (marks[i]) marks[i] = 0;
         commit_head = 0; tail_pos = 0; q_head = 0; q_tail = 0;
         wr_head = 0; limit = 0;
         seg_open = 0; dropping = 0; sending = 0; connected = 0;
         errors = 0;
      endfunction

      function int unsigned nxt(int unsigned i);
         return (i + 1 >= SLOTS) ? 0 : i + 1;
      endfunction

      function void issue(bit idle, ref tx_result r);
         int unsigned stop;
         if (q_head == q_tail || !connected || !idle) return;
         stop = 32'(marks[q_tail]);
         if (stop == 0) stop = DEPTH;
         r.start_valid = 1;
         r.start_pos = tail_pos[9:0];
         r.length = 11'((stop >= tail_pos) ? stop - tail_pos : stop + DEPTH - tail_pos);
         sending = 1;
      endfunction

      function bit merge_newest(int unsigned pos);
         int unsigned p;
         if (q_head == q_tail || nxt(q_tail) == q_head) return 0;
         p = (q_head == 0) ? SLOTS - 1 : q_head - 1;
         if (marks[p] == 0) return 0;
         marks[p] = 10'(pos);
         commit_head = pos;
         return 1;
      endfunction

      function void write_byte(logic [7:0] b, bit last, bit idle, ref tx_result r);
         int unsigned pos, nh;
         if (dropping) begin
            if (last) dropping = 0;
            return;
         end
         if (!seg_open) begin
            if (commit_head == tail_pos && q_head != q_tail) begin
               if (sending) begin
                  q_head = nxt(q_tail);
                  commit_head = 32'(marks[q_tail]);
                  if (commit_head == tail_pos) begin
                     if (!last) dropping = 1;
                     return;
                  end
               end else begin
                  q_head = 0; q_tail = 0; commit_head = 0; tail_pos = 0;
               end
            end
            wr_head = commit_head;
            limit = (commit_head < tail_pos) ? tail_pos : DEPTH;
            seg_open = 1;
         end
         if (wr_head < DEPTH) begin
            ring[wr_head] = b;
            ring_written[wr_head] = 1;
         end
         wr_head++;
         r.accepted = 1;
         if (!last && wr_head < limit) return;
         seg_open = 0;
         pos = (wr_head >= DEPTH) ? 0 : wr_head;
         if (!merge_newest(pos)) begin
            marks[q_head] = 10'(pos);
            nh = nxt(q_head);
            if (nh == q_tail) begin
               r.accepted = 0;
               if (!last) dropping = 1;
               return;
            end
            commit_head = pos;
            q_head = nh;
         end
         issue(idle, r);
      endfunction

      function void note_item(func_type op, logic [7:0] b, bit last, bit idle,
                              logic [9:0] idx);
         tx_result r;
         r = '0;
         case (op)
            FN_WRITE: write_byte(b, last, idle, r);
            FN_COMPLETE: begin
               if (q_head != q_tail) begin
                  tail_pos = 32'(marks[q_tail]);
                  q_tail = nxt(q_tail);
                  sending = 0;
                  issue(idle, r);
               end
            end
            FN_CONNECT: begin
               if (!connected) begin
                  connected = 1;
                  issue(idle, r);
               end
            end
            default: r.rdata = ring[idx];
         endcase
         pending.push_back(r);
      endfunction

      function void check_result(logic [31:0] raw);
         tx_result got, want;
         got = raw[30:0];
         if (pending.size() == 0) begin
            $display("%0t: unexpected result item %h", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.accepted !== want.accepted || got.start_valid !== want.start_valid ||
             got.start_pos !== want.start_pos || got.length !== want.length ||
             got.rdata !== want.rdata) begin
            $display("%0t: mismatch expected acc=%0d sv=%0d pos=%0d len=%0d rd=%h",
                     $realtime, want.accepted, want.start_valid, want.start_pos,
                     want.length, want.rdata);
            $display("%0t:          actual   acc=%0d sv=%0d pos=%0d len=%0d rd=%h",
                     $realtime, got.accepted, got.start_valid, got.start_pos,
                     got.length, got.rdata);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;

   chunk_ring_scoreboard board = new();
   int  cycle_count = 0;
   int  idle_pct = 35;   // set to 0 for the calm stretch

   tx_chunk_buffer_manager dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("tx_chunk_buffer_manager_tb failed");
         $finish;
      end
   end

   // result side: random stalls, check on accept
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= idle_pct);
   end

   task automatic send_item(func_type op, logic [7:0] b, bit last, bit idle,
                            logic [9:0] idx);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tlast <= last;
      req_tdata <= {5'd0, idx, idle, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(op, b, last, idle, idx);
   endtask

   // read only positions already written
   task automatic read_item(bit idle);
      int unsigned idx;
      idx = $urandom_range(DEPTH - 1);
      for (int k = 0; k < DEPTH && !board.ring_written[idx]; k++) idx = (idx + 1) % DEPTH;
      if (!board.ring_written[idx]) return;
      send_item(FN_READ, 8'h00, 0, idle, idx[9:0]);
   endtask

   task automatic write_run(int len, bit idle_last);
      for (int k = 0; k < len; k++)
         send_item(FN_WRITE, 8'($urandom_range(255)), k == len - 1,
                   (k == len - 1) ? idle_last : 1'($urandom_range(1)),
                   10'($urandom_range(1023)));
   endtask

   initial begin
      int sent, len, pick;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: writes before connect, connect, completion on empty, reads
      send_item(FN_COMPLETE, 8'hff, 1, 1, 10'h3ff);
      send_item(FN_WRITE, 8'h00, 0, 0, 10'h000);
      send_item(FN_WRITE, 8'hff, 1, 1, 10'h3ff);
      send_item(FN_WRITE, 8'ha5, 1, 1, 10'h155);
      send_item(FN_CONNECT, 8'h00, 0, 0, 10'h000);
      send_item(FN_CONNECT, 8'h00, 0, 1, 10'h000);
      send_item(FN_CONNECT, 8'h00, 0, 1, 10'h000);   // repeated connect
      send_item(FN_WRITE, 8'h5a, 1, 1, 10'h2aa);     // engine idle after connect: starts sending
      send_item(FN_READ, 8'h00, 0, 0, 10'h000);
      send_item(FN_READ, 8'h00, 0, 0, 10'h001);
      send_item(FN_COMPLETE, 8'h00, 0, 1, 10'h000);
      send_item(FN_COMPLETE, 8'h00, 0, 0, 10'h000);
      send_item(FN_COMPLETE, 8'h00, 0, 1, 10'h000);
      send_item(FN_COMPLETE, 8'h00, 0, 1, 10'h000);
      // long write wraps the ring and fills it
      write_run(1030, 0);
      // many small writes without completion; once two chunks are queued they merge into the newest
      for (int k = 0; k < 20; k++) write_run(3, 0);
      // directed items count toward the total
      sent = 14 + 1030 + 20 * 3;

      while (sent < 1700) begin
         if (sent > 1250 && sent < 1450) idle_pct = 0;
         else idle_pct = 35;
         pick = $urandom_range(99);
         if (pick < 55) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 8);
            write_run(len, $urandom_range(3) != 0);
            sent += len;
         end else if (pick < 80) begin
            send_item(FN_COMPLETE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom_range(3) != 0, 10'($urandom_range(1023)));
            sent++;
         end else if (pick < 83) begin
            send_item(FN_CONNECT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 10'($urandom_range(1023)));
            sent++;
         end else begin
            read_item(1'($urandom_range(1)));
            sent++;
         end
      end
      // one last read of a position already written
      read_item(1);
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("tx_chunk_buffer_manager_tb passed");
      else
         $display("tx_chunk_buffer_manager_tb failed");
      $finish;
   end
endmodule
